// ----- rtl/e2g_pkg.sv -----
package e2g_pkg;

    // Internal formats: angles carry 2^32 per turn, trig values are signed Q30.
    localparam int ROT_W = 34;
    localparam int VEC_W = 38;
    localparam int ZW    = 34;

    localparam logic signed [ZW-1:0] HALF_TURN    = 34'sd2147483648;
    localparam logic signed [ZW-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [VEC_W-1:0] INV_GAIN_Q30 = 38'sd652032874;

    // Register indexes of the configuration port.
    localparam logic [1:0] CFG_POLE_RA = 2'd0;
    localparam logic [1:0] CFG_TILT    = 2'd1;
    localparam logic [1:0] CFG_OFFSET  = 2'd2;

    // atan(2^-i) with 2^32 per turn.
    function automatic logic [31:0] atan_of(input int i);
        logic [31:0] t;
        case (i)
            0:  t = 32'd536870912;
            1:  t = 32'd316933406;
            2:  t = 32'd167458907;
            3:  t = 32'd85004756;
            4:  t = 32'd42667331;
            5:  t = 32'd21354465;
            6:  t = 32'd10679838;
            7:  t = 32'd5340245;
            8:  t = 32'd2670163;
            9:  t = 32'd1335087;
            10: t = 32'd667544;
            11: t = 32'd333772;
            12: t = 32'd166886;
            13: t = 32'd83443;
            14: t = 32'd41722;
            15: t = 32'd20861;
            16: t = 32'd10430;
            17: t = 32'd5215;
            18: t = 32'd2608;
            19: t = 32'd1304;
            20: t = 32'd652;
            21: t = 32'd326;
            22: t = 32'd163;
            23: t = 32'd81;
            24: t = 32'd41;
            25: t = 32'd20;
            26: t = 32'd10;
            27: t = 32'd5;
            28: t = 32'd3;
            29: t = 32'd1;
            30: t = 32'd1;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

    // Q30 product rounded half up. Every operand (sines, cosines, their products
    // and the gain-scaled radius) stays within plus or minus 2^31, so a 32 by 32
    // signed multiply covers it.
    function automatic logic signed [VEC_W-1:0] mul_q30(
        input logic signed [VEC_W-1:0] a,
        input logic signed [VEC_W-1:0] b
    );
        logic signed [31:0] a32, b32;
        logic signed [63:0] p;
        a32 = a[31:0];
        b32 = b[31:0];
        p   = a32 * b32 + 64'sd536870912;
        return VEC_W'(p >>> 30);
    endfunction

endpackage

// ----- rtl/e2g_rotate.sv -----
module e2g_rotate #(
    parameter int STAGES = 24
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_ce,
    input  logic                        i_valid,
    input  logic [31:0]                 i_angle,
    output logic                        o_valid,
    output logic signed [e2g_pkg::ROT_W-1:0] o_cos,
    output logic signed [e2g_pkg::ROT_W-1:0] o_sin
);
    import e2g_pkg::*;

    logic signed [ROT_W-1:0] r_x [0:STAGES];
    logic signed [ROT_W-1:0] r_y [0:STAGES];
    logic signed [ZW-1:0]    r_z [0:STAGES];
    logic                    r_flip [0:STAGES];
    logic                    r_v [0:STAGES];

    logic signed [ZW-1:0] n_z0;
    logic                 n_flip0;

    // Fold the angle into plus or minus a quarter turn.
    always_comb begin
        n_z0    = ZW'($signed(i_angle));
        n_flip0 = 1'b0;
        if (n_z0 > QUARTER_TURN) begin
            n_z0    = n_z0 - HALF_TURN;
            n_flip0 = 1'b1;
        end else if (n_z0 < -QUARTER_TURN) begin
            n_z0    = n_z0 + HALF_TURN;
            n_flip0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_x[0]    <= ROT_W'(INV_GAIN_Q30);
            r_y[0]    <= '0;
            r_z[0]    <= n_z0;
            r_flip[0] <= n_flip0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_ce) begin
            r_v[0] <= i_valid;
        end
    end

    // One rotation step per stage.
    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam logic signed [ZW-1:0] T = ZW'(atan_of(k));
        logic signed [ROT_W-1:0] dx, dy;
        assign dx = r_y[k] >>> k;
        assign dy = r_x[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                if (r_z[k] >= 0) begin
                    r_x[k+1] <= r_x[k] - dx;
                    r_y[k+1] <= r_y[k] + dy;
                    r_z[k+1] <= r_z[k] - T;
                end else begin
                    r_x[k+1] <= r_x[k] + dx;
                    r_y[k+1] <= r_y[k] - dy;
                    r_z[k+1] <= r_z[k] + T;
                end
                r_flip[k+1] <= r_flip[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_ce) begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    assign o_valid = r_v[STAGES];
    assign o_cos   = r_flip[STAGES] ? -r_x[STAGES] : r_x[STAGES];
    assign o_sin   = r_flip[STAGES] ? -r_y[STAGES] : r_y[STAGES];

endmodule

// ----- rtl/e2g_vector.sv -----
module e2g_vector #(
    parameter int STAGES = 24,
    parameter int SIDE_W = 34
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_ce,
    input  logic                             i_valid,
    input  logic signed [e2g_pkg::VEC_W-1:0] i_x,
    input  logic signed [e2g_pkg::VEC_W-1:0] i_y,
    input  logic [SIDE_W-1:0]                i_side,
    output logic                             o_valid,
    output logic signed [e2g_pkg::ZW-1:0]    o_angle,
    output logic signed [e2g_pkg::VEC_W-1:0] o_mag,
    output logic [SIDE_W-1:0]                o_side
);
    import e2g_pkg::*;

    logic signed [VEC_W-1:0] r_x [0:STAGES];
    logic signed [VEC_W-1:0] r_y [0:STAGES];
    logic signed [ZW-1:0]    r_z [0:STAGES];
    logic                    r_zero [0:STAGES];
    logic [SIDE_W-1:0]       r_side [0:STAGES];
    logic                    r_v [0:STAGES];

    // Move the vector into the right half plane.
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            if (i_x < 0) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= HALF_TURN;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
            r_zero[0] <= (i_x == 0) && (i_y == 0);
            r_side[0] <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_ce) begin
            r_v[0] <= i_valid;
        end
    end

    // One vectoring step per stage.
    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam logic signed [ZW-1:0] T = ZW'(atan_of(k));
        logic signed [VEC_W-1:0] dx, dy;
        assign dx = r_y[k] >>> k;
        assign dy = r_x[k] >>> k;

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                if (r_y[k] > 0) begin
                    r_x[k+1] <= r_x[k] + dx;
                    r_y[k+1] <= r_y[k] - dy;
                    r_z[k+1] <= r_z[k] + T;
                end else begin
                    r_x[k+1] <= r_x[k] - dx;
                    r_y[k+1] <= r_y[k] + dy;
                    r_z[k+1] <= r_z[k] - T;
                end
                r_zero[k+1] <= r_zero[k];
                r_side[k+1] <= r_side[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_ce) begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    // A zero vector has angle and radius zero.
    assign o_valid = r_v[STAGES];
    assign o_angle = r_zero[STAGES] ? '0 : r_z[STAGES];
    assign o_mag   = r_zero[STAGES] ? '0 : r_x[STAGES];
    assign o_side  = r_side[STAGES];

endmodule

// ----- rtl/equatorial_to_galactic_unit.sv -----
// Channel  Direction  Handshake                   Payload
// s_axis   in         i_s_axis_tvalid/o_..tready  right ascension, declination
// m_axis   out        o_m_axis_tvalid/i_..tready  galactic longitude, latitude
// cfg      in         i_cfg_valid/o_cfg_ready     register index, write data
//
// One beat enters per cycle while the output is not stalled; its result is presented
// once it has passed three CORDIC stage chains one after the other (sine/cosine,
// then the two vectoring passes, each CORDIC_STAGES + 1 registers deep) plus two
// product stages, the gain stage and the output register.
// Reset clears all valid bits and loads the default pole, tilt and offset registers.
// While the output beat waits, the whole pipeline holds; nothing is lost.
module equatorial_to_galactic_unit #(
    parameter int ANGLE_BITS    = 24,
    parameter int CORDIC_STAGES = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // right_ascension, declination
    input  logic [((2*ANGLE_BITS+7)/8)*8-1:0]  i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // galactic_longitude, galactic_latitude
    output logic [((2*ANGLE_BITS+7)/8)*8-1:0]  o_m_axis_tdata,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_index,
    input  logic [ANGLE_BITS-1:0]              i_cfg_data
);
    import e2g_pkg::*;

    localparam int AB     = ANGLE_BITS;
    localparam int DW     = ((2*AB+7)/8)*8;
    localparam int S      = 32 - AB;
    localparam longint HALF_S = (S == 0) ? 0 : (64'sd1 <<< (S-1));
    localparam logic [AB-1:0] RST_RA  = AB'(((64'd8959545 << 8) + HALF_S) >> S);
    localparam logic [AB-1:0] RST_TLT = AB'(((64'd1276921 << 8) + HALF_S) >> S);
    localparam logic [AB-1:0] RST_OFF = AB'(((64'd14120823 << 8) + HALF_S) >> S);
    localparam logic signed [ZW-1:0] LIM = ZW'(64'sd1 <<< (AB-2));

    logic ce;
    logic r_out_v;
    logic [AB-1:0] r_out_lon, r_out_lat;
    logic [AB-1:0] r_pole_ra, r_tilt, r_offset;

    assign ce              = !r_out_v || i_m_axis_tready;
    assign o_s_axis_tready = ce;
    assign o_cfg_ready     = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pole_ra <= RST_RA;
            r_tilt    <= RST_TLT;
            r_offset  <= RST_OFF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POLE_RA: r_pole_ra <= i_cfg_data;
                CFG_TILT:    r_tilt    <= i_cfg_data;
                CFG_OFFSET:  r_offset  <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // Input angles in the 2^32 per turn domain.
    logic [31:0] ra_w, dec_w, xang_w, tilt_w;
    logic        in_v;
    assign ra_w   = 32'(i_s_axis_tdata[AB-1:0]) << S;
    assign dec_w  = 32'(i_s_axis_tdata[2*AB-1:AB]) << S;
    assign tilt_w = 32'(r_tilt) << S;
    assign xang_w = (32'(r_pole_ra) << S) - ra_w;
    assign in_v   = i_s_axis_tvalid;

    logic v_dec, v_x, v_g;
    logic signed [ROT_W-1:0] cd, sd, cx, sx, cg, sg;

    e2g_rotate #(.STAGES(CORDIC_STAGES)) u_rot_dec (
        .i_clk, .i_rst_n, .i_ce(ce), .i_valid(in_v), .i_angle(dec_w),
        .o_valid(v_dec), .o_cos(cd), .o_sin(sd)
    );
    e2g_rotate #(.STAGES(CORDIC_STAGES)) u_rot_x (
        .i_clk, .i_rst_n, .i_ce(ce), .i_valid(in_v), .i_angle(xang_w),
        .o_valid(v_x), .o_cos(cx), .o_sin(sx)
    );
    e2g_rotate #(.STAGES(CORDIC_STAGES)) u_rot_g (
        .i_clk, .i_rst_n, .i_ce(ce), .i_valid(in_v), .i_angle(tilt_w),
        .o_valid(v_g), .o_cos(cg), .o_sin(sg)
    );

    // First product stage.
    logic r_a_v;
    logic signed [VEC_W-1:0] r_cdcx, r_nx, r_sdsg, r_sdcg, r_sg, r_cg;
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_cdcx <= mul_q30(VEC_W'(cd), VEC_W'(cx));
            r_nx   <= mul_q30(VEC_W'(cd), VEC_W'(sx));
            r_sdsg <= mul_q30(VEC_W'(sd), VEC_W'(sg));
            r_sdcg <= mul_q30(VEC_W'(sd), VEC_W'(cg));
            r_sg   <= VEC_W'(sg);
            r_cg   <= VEC_W'(cg);
        end
    end

    // Second product stage forms the rotated vector.
    logic r_b_v;
    logic signed [VEC_W-1:0] r_ny, r_nz, r_nx2;
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_ny  <= mul_q30(r_cdcx, r_sg) - r_sdcg;
            r_nz  <= r_sdsg + mul_q30(r_cdcx, r_cg);
            r_nx2 <= r_nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else if (ce) begin
            r_a_v <= v_dec & v_x & v_g;
            r_b_v <= r_a_v;
        end
    end

    // Longitude angle and equatorial radius.
    logic v1_v;
    logic signed [ZW-1:0]    ang1;
    logic signed [VEC_W-1:0] mag1;
    logic [VEC_W-1:0]        nz1;

    e2g_vector #(.STAGES(CORDIC_STAGES), .SIDE_W(VEC_W)) u_vec_lon (
        .i_clk, .i_rst_n, .i_ce(ce), .i_valid(r_b_v),
        .i_x(r_ny), .i_y(r_nx2), .i_side(r_nz),
        .o_valid(v1_v), .o_angle(ang1), .o_mag(mag1), .o_side(nz1)
    );

    // Remove the CORDIC gain from the radius.
    logic r_r_v;
    logic signed [VEC_W-1:0] r_r, r_nz3;
    logic signed [ZW-1:0]    r_ang;
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_r   <= mul_q30(mag1, INV_GAIN_Q30);
            r_nz3 <= $signed(nz1);
            r_ang <= ang1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_v <= 1'b0;
        end else if (ce) begin
            r_r_v <= v1_v;
        end
    end

    // Latitude as atan2 of height over radius.
    logic v2_v;
    logic signed [ZW-1:0]    ang2;
    logic signed [VEC_W-1:0] mag2;
    logic [ZW-1:0]           lon_ang;

    e2g_vector #(.STAGES(CORDIC_STAGES), .SIDE_W(ZW)) u_vec_lat (
        .i_clk, .i_rst_n, .i_ce(ce), .i_valid(r_r_v),
        .i_x(r_r), .i_y(r_nz3), .i_side(r_ang),
        .o_valid(v2_v), .o_angle(ang2), .o_mag(mag2), .o_side(lon_ang)
    );

    // Final rounding and saturation.
    logic [31:0]          lon32;
    logic [32:0]          lon_sum;
    logic signed [ZW-1:0] lat_c, lat_r, lat_s;
    always_comb begin
        lon32   = (32'(r_offset) << S) - lon_ang[31:0];
        lon_sum = {1'b0, lon32} + 33'(HALF_S);
        lat_c   = ang2;
        if (lat_c > QUARTER_TURN) begin
            lat_c = QUARTER_TURN;
        end
        if (lat_c < -QUARTER_TURN) begin
            lat_c = -QUARTER_TURN;
        end
        lat_r = (lat_c + ZW'(HALF_S)) >>> S;
        lat_s = lat_r;
        if (lat_r > LIM) begin
            lat_s = LIM;
        end
        if (lat_r < -LIM) begin
            lat_s = -LIM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_out_lon <= lon_sum[S +: AB];
            r_out_lat <= lat_s[AB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (ce) begin
            r_out_v <= v2_v;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = DW'({r_out_lat, r_out_lon});

    // The magnitude of the latitude pass is not part of the result.
    logic unused_mag;
    assign unused_mag = ^mag2;

    a_lat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> ($signed(r_out_lat) <= $signed(LIM[AB-1:0]) || AB < 3) &&
                    ($signed(r_out_lat) >= -$signed(LIM[AB-1:0]) || AB < 3))
        else $error("latitude beyond a quarter turn");

    a_tilt_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && i_cfg_index == CFG_TILT) |=> r_tilt == $past(i_cfg_data))
        else $error("tilt register write lost");

    a_offset_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && i_cfg_index == CFG_OFFSET) |=> r_offset == $past(i_cfg_data))
        else $error("offset register write lost");

    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (v_dec == v_x) && (v_x == v_g))
        else $error("sine and cosine lanes out of step");

endmodule
